>>> rtl/multi_channel_byte_fifo_macros.svh
// Assertion macros used by the checker file of the byte queue block.
`ifndef MULTI_CHANNEL_BYTE_FIFO_MACROS_SVH
`define MULTI_CHANNEL_BYTE_FIFO_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MCBF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mcbf assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is held.
`define MCBF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mcbf assertion failed (next cycle)");

`endif

>>> rtl/mcbf_pkg.sv
`default_nettype none

package mcbf_pkg;

    localparam int ACTION_W  = 3;
    localparam int CHANNEL_W = 4;
    localparam int BYTE_W    = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_OPEN    = 3'd0,
        ACT_CLOSE   = 3'd1,
        ACT_SEND    = 3'd2,
        ACT_DEQUEUE = 3'd3,
        ACT_QUERY   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_READ = 2'd2
    } t_state;

    typedef struct packed {
        logic capture;      // register the accepted request
        logic commit;       // apply the request to the channel state
        logic load_result;  // load the output register from the decision
        logic load_read;    // load the output register from the store
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_read;    // a dequeue that succeeds and must read the store
        logic out_free;     // the output register can take a result this cycle
    } t_dp_status;

endpackage

`default_nettype wire

>>> rtl/mcbf_ram.sv
`default_nettype none

module mcbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                     i_wr_data,
    input  wire logic                                 i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/mcbf_ctrl.sv
`default_nettype none

module mcbf_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire mcbf_pkg::t_dp_status   i_status,
    output mcbf_pkg::t_ctrl_cmd         o_cmd
);

    import mcbf_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_ctrl_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.out_free) begin
                    n_state = i_status.need_read ? ST_READ : ST_IDLE;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd        = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                cmd.capture = i_in_valid;
            end
            ST_EXEC: begin
                // Wait here until the previous result has left the output register.
                if (i_status.out_free) begin
                    cmd.commit      = 1'b1;
                    cmd.load_result = !i_status.need_read;
                end
            end
            ST_READ: begin
                cmd.load_read = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign o_cmd = cmd;

endmodule

`default_nettype wire

>>> rtl/mcbf_dp.sv
`default_nettype none

module mcbf_dp #(
    parameter int CHANNELS    = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire mcbf_pkg::t_ctrl_cmd            i_cmd,
    output mcbf_pkg::t_dp_status                o_status,
    input  wire logic [mcbf_pkg::ACTION_W-1:0]  i_action,
    input  wire logic [mcbf_pkg::CHANNEL_W-1:0] i_channel,
    input  wire logic [mcbf_pkg::BYTE_W-1:0]    i_byte_in,
    input  wire logic                           i_out_stall,
    output logic                                o_out_valid,
    output logic                                o_ok,
    output logic      [mcbf_pkg::BYTE_W-1:0]    o_byte_out,
    output logic                                o_is_empty
);

    import mcbf_pkg::*;

    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_D  = CHANNELS * QUEUE_DEPTH;
    localparam int ADDR_W   = (STORE_D > 1) ? $clog2(STORE_D) : 1;

    localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]     FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0]    DEPTH_A  = ADDR_W'(QUEUE_DEPTH);
    localparam logic [CHANNEL_W:0]   CH_LIMIT = (CHANNEL_W + 1)'(CHANNELS);

    // Registered request.
    logic [ACTION_W-1:0]  r_action;
    logic [CHANNEL_W-1:0] r_channel;
    logic [BYTE_W-1:0]    r_byte_in;

    // Per-channel control state.
    logic             r_open  [CHANNELS];
    logic [IDX_W-1:0] r_rd_idx[CHANNELS];
    logic [IDX_W-1:0] r_wr_idx[CHANNELS];
    logic [CNT_W-1:0] r_fill  [CHANNELS];

    // Output register.
    logic              r_out_valid;
    logic              n_out_valid;
    logic              r_ok;
    logic [BYTE_W-1:0] r_byte_out;
    logic              r_is_empty;

    logic              ch_valid;
    logic [CH_W-1:0]   sel;
    logic              is_open;
    logic [IDX_W-1:0]  cur_rd;
    logic [IDX_W-1:0]  cur_wr;
    logic [CNT_W-1:0]  cur_fill;
    logic              send_ok;
    logic              deq_ok;
    logic              res_ok;
    logic              res_empty;
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] ram_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action  <= i_action;
            r_channel <= i_channel;
            r_byte_in <= i_byte_in;
        end
    end

    always_comb begin
        ch_valid = {1'b0, r_channel} < CH_LIMIT;
        sel      = r_channel[CH_W-1:0];
        is_open  = 1'b0;
        cur_rd   = '0;
        cur_wr   = '0;
        cur_fill = '0;
        if (ch_valid) begin
            is_open  = r_open[sel];
            cur_rd   = r_rd_idx[sel];
            cur_wr   = r_wr_idx[sel];
            cur_fill = r_fill[sel];
        end
        send_ok = is_open && (cur_fill != FULL_CNT);
        deq_ok  = is_open && (cur_fill != '0);
    end

    always_comb begin
        res_ok    = 1'b0;
        res_empty = 1'b0;
        ram_wr_en = 1'b0;
        ram_rd_en = 1'b0;
        case (r_action)
            ACT_OPEN, ACT_CLOSE: begin
                res_ok = ch_valid;
            end
            ACT_SEND: begin
                res_ok    = send_ok;
                ram_wr_en = i_cmd.commit && send_ok;
            end
            ACT_DEQUEUE: begin
                res_ok    = deq_ok;
                ram_rd_en = i_cmd.commit && deq_ok;
            end
            ACT_QUERY: begin
                res_ok    = 1'b1;
                res_empty = !deq_ok;
            end
            default: begin
                res_ok = 1'b0;
            end
        endcase
    end

    assign o_status = '{
        need_read: (r_action == ACT_DEQUEUE) && deq_ok,
        out_free:  !r_out_valid || !i_out_stall
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_open[c]   <= 1'b0;
                r_rd_idx[c] <= '0;
                r_wr_idx[c] <= '0;
                r_fill[c]   <= '0;
            end
        end else if (i_cmd.commit && ch_valid) begin
            case (r_action)
                ACT_OPEN, ACT_CLOSE: begin
                    r_open[sel]   <= (r_action == ACT_OPEN);
                    r_rd_idx[sel] <= '0;
                    r_wr_idx[sel] <= '0;
                    r_fill[sel]   <= '0;
                end
                ACT_SEND: begin
                    if (send_ok) begin
                        r_wr_idx[sel] <= (cur_wr == LAST_IDX) ? '0 : cur_wr + 1'b1;
                        r_fill[sel]   <= cur_fill + 1'b1;
                    end
                end
                ACT_DEQUEUE: begin
                    if (deq_ok) begin
                        r_rd_idx[sel] <= (cur_rd == LAST_IDX) ? '0 : cur_rd + 1'b1;
                        r_fill[sel]   <= cur_fill - 1'b1;
                    end
                end
                default: begin
                    r_open[sel] <= r_open[sel];
                end
            endcase
        end
    end

    // Each channel owns a contiguous slice of QUEUE_DEPTH entries in the store.
    assign base_addr = ADDR_W'(sel) * DEPTH_A;
    assign wr_addr   = base_addr + ADDR_W'(cur_wr);
    assign rd_addr   = base_addr + ADDR_W'(cur_rd);

    mcbf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_D)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_byte_in),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.load_result || i_cmd.load_read) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_ok       <= res_ok;
            r_byte_out <= '0;
            r_is_empty <= res_empty;
        end else if (i_cmd.load_read) begin
            r_ok       <= 1'b1;
            r_byte_out <= ram_rd_data;
            r_is_empty <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_ok;
    assign o_byte_out  = r_byte_out;
    assign o_is_empty  = r_is_empty;

endmodule

`default_nettype wire

>>> rtl/multi_channel_byte_fifo.sv
// A set of CHANNELS independent byte queues, each QUEUE_DEPTH entries deep
// and each with its own open flag, sharing one byte store with a write port
// and a registered read port. Every accepted request (open, close, send,
// dequeue or empty query on one channel) returns exactly one result
// transaction carrying ok, byte_out and is_empty. The request is registered
// and the result is loaded into the output register from the execute step,
// or, for a dequeue that returns data, from the registered store read in a
// separate read step; the next request is accepted in the cycle after the
// result is loaded, so a new request is taken only once the last is done.
// When the previous result is still held by a downstream stall, a new request
// waits in the execute step until the output register frees. The byte store
// is not cleared after reset and needs no clearing pass: a dequeue only ever
// reads entries written since its channel was last opened.
`default_nettype none

module multi_channel_byte_fifo #(
    parameter int CHANNELS    = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [mcbf_pkg::ACTION_W-1:0]  i_action,
    input  wire logic [mcbf_pkg::CHANNEL_W-1:0] i_channel,
    input  wire logic [mcbf_pkg::BYTE_W-1:0]    i_byte_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_ok,
    output logic      [mcbf_pkg::BYTE_W-1:0]    o_byte_out,
    output logic                                o_is_empty
);

    import mcbf_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    mcbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mcbf_dp #(
        .CHANNELS    (CHANNELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_action    (i_action),
        .i_channel   (i_channel),
        .i_byte_in   (i_byte_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_ok        (o_ok),
        .o_byte_out  (o_byte_out),
        .o_is_empty  (o_is_empty)
    );

endmodule

`default_nettype wire

>>> rtl/mcbf_checker.sv
`default_nettype none
`include "multi_channel_byte_fifo_macros.svh"

module mcbf_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire logic                           o_ok,
    input wire logic [mcbf_pkg::BYTE_W-1:0]    o_byte_out,
    input wire logic                           o_is_empty
);

    import mcbf_pkg::*;

    logic              in_txn;
    logic [BYTE_W+1:0] out_payload;

    assign in_txn      = i_in_valid && !o_in_stall;
    assign out_payload = {o_ok, o_byte_out, o_is_empty};

    // A held result must not change while the consumer stalls.
    `MCBF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(out_payload))

    // One request at a time: the block is busy straight after taking a transaction.
    `MCBF_ASSERT_NEXT(a_busy_after_accept, in_txn, o_in_stall)

    // A failed request never carries data.
    `MCBF_ASSERT_NOW(a_fail_no_data, o_out_valid && !o_ok, o_byte_out == '0 && !o_is_empty)

    // Only the query reports empty, and the query always succeeds.
    `MCBF_ASSERT_NOW(a_empty_is_query, o_out_valid && o_is_empty, o_ok && o_byte_out == '0)

endmodule

bind multi_channel_byte_fifo mcbf_checker u_checker (.*);

`default_nettype wire

>>> tb/sv/multi_channel_byte_fifo_checker.sv
module multi_channel_byte_fifo_checker #(
    parameter int CHANNELS    = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_req_valid,
    input  wire logic                           i_req_stall,
    input  wire logic [mcbf_pkg::ACTION_W-1:0]  i_action,
    input  wire logic [mcbf_pkg::CHANNEL_W-1:0] i_channel,
    input  wire logic [mcbf_pkg::BYTE_W-1:0]    i_byte_in,
    input  wire logic                           i_rsp_valid,
    input  wire logic                           i_rsp_stall,
    input  wire logic                           i_ok,
    input  wire logic [mcbf_pkg::BYTE_W-1:0]    i_byte_out,
    input  wire logic                           i_is_empty,
    output int                                  o_errors,
    output int                                  o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import mcbf_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              ok;
        logic [BYTE_W-1:0] byte_out;
        logic              is_empty;
    } t_fifo_reply;

    // Shadow copy of every channel's queue.
    bit                chan_open  [CHANNELS];
    logic [PTR_W-1:0]  rd_ptr     [CHANNELS];
    logic [PTR_W-1:0]  wr_ptr     [CHANNELS];
    logic [FILL_W-1:0] fill_level [CHANNELS];
    logic [BYTE_W-1:0] byte_store [CHANNELS][QUEUE_DEPTH];

    t_fifo_reply pending_replies[$];
    int          error_count = 0;
    int          reply_index = 0;

    assign o_errors = error_count;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: reply %0d: %s", $time, reply_index, what);
        error_count++;
    endtask

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    // Applies one request to the shadow queues and returns the reply it earns.
    function automatic t_fifo_reply serve_request(
        input logic [ACTION_W-1:0]  act,
        input logic [CHANNEL_W-1:0] ch,
        input logic [BYTE_W-1:0]    data
    );
        t_fifo_reply reply;
        bit          known;
        int          c;
        reply = '0;
        c     = int'(ch);
        known = c < CHANNELS;
        case (act)
            ACT_OPEN, ACT_CLOSE: begin
                if (known) begin
                    chan_open[c]  = (act == ACT_OPEN);
                    rd_ptr[c]     = '0;
                    wr_ptr[c]     = '0;
                    fill_level[c] = '0;
                    reply.ok      = 1'b1;
                end
            end
            ACT_SEND: begin
                if (known && chan_open[c] && fill_level[c] < QUEUE_DEPTH) begin
                    byte_store[c][wr_ptr[c]] = data;
                    wr_ptr[c]     = next_slot(wr_ptr[c]);
                    fill_level[c] = fill_level[c] + 1'b1;
                    reply.ok      = 1'b1;
                end
            end
            ACT_DEQUEUE: begin
                if (known && chan_open[c] && fill_level[c] != 0) begin
                    reply.byte_out = byte_store[c][rd_ptr[c]];
                    rd_ptr[c]      = next_slot(rd_ptr[c]);
                    fill_level[c]  = fill_level[c] - 1'b1;
                    reply.ok       = 1'b1;
                end
            end
            ACT_QUERY: begin
                reply.ok       = 1'b1;
                reply.is_empty = !(known && chan_open[c] && fill_level[c] != 0);
            end
            default: begin
            end
        endcase
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_fifo_reply want;
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                chan_open[k]  = 1'b0;
                rd_ptr[k]     = '0;
                wr_ptr[k]     = '0;
                fill_level[k] = '0;
            end
            pending_replies.delete();
        end else begin
            // A request and the reply it causes never share an edge, so the
            // request side is handled first.
            if (i_req_valid && !i_req_stall) begin
                pending_replies.push_back(serve_request(i_action, i_channel, i_byte_in));
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch("reply with no request outstanding");
                end else begin
                    want = pending_replies.pop_front();
                    if (i_ok !== want.ok) begin
                        report_mismatch($sformatf("ok got %b, expected %b", i_ok, want.ok));
                    end
                    if (i_byte_out !== want.byte_out) begin
                        report_mismatch($sformatf("byte_out got %02h, expected %02h",
                                                  i_byte_out, want.byte_out));
                    end
                    if (i_is_empty !== want.is_empty) begin
                        report_mismatch($sformatf("is_empty got %b, expected %b",
                                                  i_is_empty, want.is_empty));
                    end
                end
                reply_index++;
            end
        end
        o_outstanding <= pending_replies.size();
    end

endmodule

>>> tb/sv/multi_channel_byte_fifo_test.sv
module multi_channel_byte_fifo_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mcbf_pkg::*;

    localparam int CHANNELS     = 8;
    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1450;
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [CHANNEL_W-1:0] LAST_CHANNEL_CODE  = '1;
    localparam logic [ACTION_W-1:0]  ACT_UNKNOWN_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0]  ACT_UNKNOWN_LAST  = 3'd7;

    typedef enum int {
        MOOD_FILL,
        MOOD_DRAIN,
        MOOD_MIXED
    } t_traffic_mood;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [ACTION_W-1:0]  i_action;
    logic [CHANNEL_W-1:0] i_channel;
    logic [BYTE_W-1:0]    i_byte_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_ok;
    logic [BYTE_W-1:0]    o_byte_out;
    logic                 o_is_empty;

    int          error_total;
    int          replies_owed;
    int unsigned cycle_count = 0;

    multi_channel_byte_fifo #(
        .CHANNELS    (CHANNELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_channel   (i_channel),
        .i_byte_in   (i_byte_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ok        (o_ok),
        .o_byte_out  (o_byte_out),
        .o_is_empty  (o_is_empty)
    );

    multi_channel_byte_fifo_checker #(
        .CHANNELS    (CHANNELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_in_valid),
        .i_req_stall   (o_in_stall),
        .i_action      (i_action),
        .i_channel     (i_channel),
        .i_byte_in     (i_byte_in),
        .i_rsp_valid   (o_out_valid),
        .i_rsp_stall   (i_out_stall),
        .i_ok          (o_ok),
        .i_byte_out    (o_byte_out),
        .i_is_empty    (o_is_empty),
        .o_errors      (error_total),
        .o_outstanding (replies_owed)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly no gap, some short ones and the odd long one.
    function automatic int idle_cycles(input bit steady);
        int r;
        r = $urandom_range(99);
        if (steady || r < 55) return 0;
        if (r < 88) return $urandom_range(3, 1);
        return $urandom_range(25, 4);
    endfunction

    function automatic logic [ACTION_W-1:0] pick_action(input t_traffic_mood mood);
        int r;
        int w_send;
        int w_deq;
        r = $urandom_range(99);
        case (mood)
            MOOD_FILL:  begin w_send = 65; w_deq = 18; end
            MOOD_DRAIN: begin w_send = 18; w_deq = 65; end
            default:    begin w_send = 42; w_deq = 41; end
        endcase
        if (r < w_send) return ACT_SEND;
        if (r < w_send + w_deq) return ACT_DEQUEUE;
        if (r < 91) return ACT_QUERY;
        if (r < 95) return ACT_OPEN;
        if (r < 98) return ACT_CLOSE;
        return ACTION_W'($urandom_range(ACT_UNKNOWN_LAST, ACT_UNKNOWN_FIRST));
    endfunction

    function automatic logic [CHANNEL_W-1:0] pick_channel(input int hot_channel);
        int r;
        r = $urandom_range(99);
        if (r < 75) return CHANNEL_W'(hot_channel);
        if (r < 90) return CHANNEL_W'($urandom_range(CHANNELS - 1, 0));
        return CHANNEL_W'($urandom_range(LAST_CHANNEL_CODE, CHANNELS));
    endfunction

    // Entered and left just after a falling edge; returns once the request
    // has been accepted.
    task automatic issue_request(
        input logic [ACTION_W-1:0]  act,
        input logic [CHANNEL_W-1:0] ch,
        input logic [BYTE_W-1:0]    data,
        input int                   gap
    );
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action   = act;
        i_channel  = ch;
        i_byte_in  = data;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Downstream stall: quiet stretches broken by stalls of varying length.
    initial begin
        int run;
        int hold;
        i_out_stall = 1'b0;
        forever begin
            run = ($urandom_range(9) == 0) ? $urandom_range(150, 40) : $urandom_range(12, 0);
            repeat (run) @(negedge i_clk);
            hold = ($urandom_range(4) != 0) ? $urandom_range(3, 1) : $urandom_range(30, 4);
            i_out_stall = 1'b1;
            repeat (hold) @(negedge i_clk);
            i_out_stall = 1'b0;
        end
    end

    initial begin
        int            issued;
        int            hot_channel;
        int            burst_len;
        bit            steady;
        t_traffic_mood mood;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_action   = ACT_QUERY;
        i_channel  = '0;
        i_byte_in  = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Every channel starts closed.
        issue_request(ACT_QUERY, CHANNEL_W'(0), 8'h00, 0);
        issue_request(ACT_SEND, CHANNEL_W'(0), 8'hA5, 0);
        issue_request(ACT_DEQUEUE, CHANNEL_W'(0), 8'h00, 0);

        // Channel numbers beyond the last channel.
        issue_request(ACT_OPEN, LAST_CHANNEL_CODE, 8'h00, 0);
        issue_request(ACT_CLOSE, CHANNEL_W'(CHANNELS), 8'h00, 0);
        issue_request(ACT_SEND, CHANNEL_W'(CHANNELS + 1), 8'hFF, 0);
        issue_request(ACT_DEQUEUE, LAST_CHANNEL_CODE, 8'h00, 0);
        issue_request(ACT_QUERY, LAST_CHANNEL_CODE, 8'h00, 0);

        // Extremes of the data byte, then a dequeue from an empty channel.
        issue_request(ACT_OPEN, CHANNEL_W'(0), 8'h00, 0);
        issue_request(ACT_SEND, CHANNEL_W'(0), 8'h00, 0);
        issue_request(ACT_SEND, CHANNEL_W'(0), 8'hFF, 1);
        issue_request(ACT_QUERY, CHANNEL_W'(0), 8'h00, 0);
        issue_request(ACT_DEQUEUE, CHANNEL_W'(0), 8'h00, 0);
        issue_request(ACT_DEQUEUE, CHANNEL_W'(0), 8'h00, 2);
        issue_request(ACT_DEQUEUE, CHANNEL_W'(0), 8'h00, 0);
        issue_request(ACT_QUERY, CHANNEL_W'(0), 8'h00, 0);

        // Reopening an open channel throws away what it holds.
        issue_request(ACT_OPEN, CHANNEL_W'(CHANNELS - 1), 8'h00, 0);
        issue_request(ACT_SEND, CHANNEL_W'(CHANNELS - 1), 8'h5A, 0);
        issue_request(ACT_OPEN, CHANNEL_W'(CHANNELS - 1), 8'h00, 0);
        issue_request(ACT_QUERY, CHANNEL_W'(CHANNELS - 1), 8'h00, 0);
        issue_request(ACT_DEQUEUE, CHANNEL_W'(CHANNELS - 1), 8'h00, 0);

        // Closing a channel that is already closed still succeeds.
        issue_request(ACT_CLOSE, CHANNEL_W'(3), 8'h00, 0);

        for (int a = ACT_UNKNOWN_FIRST; a <= ACT_UNKNOWN_LAST; a++) begin
            issue_request(ACTION_W'(a), CHANNEL_W'(0), 8'h3C, 0);
        end

        // Bursts that dwell on one channel long enough to fill it, wrap its
        // pointers and drain it again.
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            hot_channel = $urandom_range(CHANNELS - 1, 0);
            mood        = t_traffic_mood'($urandom_range(2));
            burst_len   = $urandom_range(60, 12);
            steady      = ($urandom_range(3) == 0);
            if ($urandom_range(1) == 0) begin
                issue_request(ACT_OPEN, CHANNEL_W'(hot_channel), BYTE_W'($urandom),
                              idle_cycles(steady));
                issued++;
            end
            for (int k = 0; k < burst_len && issued < RANDOM_ITEMS; k++) begin
                issue_request(pick_action(mood), pick_channel(hot_channel),
                              BYTE_W'($urandom), idle_cycles(steady));
                issued++;
            end
        end
        i_in_valid = 1'b0;

        while (replies_owed != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_total == 0 && replies_owed == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
